// ===== hw/rtl/spq_pkg.sv =====
// spq_pkg: shared types and constants for the sorted priority queue
// holds the entry type, cell control struct and command codes
// no dependencies
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 16;
    localparam int COUNT_W  = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] prio;
        logic signed [DATA_W-1:0] payload;
    } t_entry;

    // per-cell control, one copy for each cell
    typedef struct packed {
        logic insert;
        logic remove;
        logic occupied;
        logic at_tail;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// spq_cell: one slot of the sorted queue, holds an entry and shifts it
// to a neighbour on insert or remove
// depends on spq_pkg
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  spq_pkg::t_entry    i_new,
    input  spq_pkg::t_entry    i_left,
    input  logic               i_left_ge,
    input  spq_pkg::t_entry    i_right,
    output spq_pkg::t_entry    o_entry,
    output spq_pkg::t_entry    o_next,
    output logic               o_ge
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // stored entry not below the new priority: it moves one place up
    assign o_ge = i_ctl.occupied && (r_entry.prio >= i_new.prio);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert) begin
            if (i_left_ge) begin
                n_entry = i_left;
            end else if (o_ge || i_ctl.at_tail) begin
                n_entry = i_new;
            end
        end else if (i_ctl.remove) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

// ===== hw/rtl/sorted_priority_queue_core.sv =====
// sorted_priority_queue_core: shift-register priority queue, one word per cycle unless the result output stalls
// result: registered, shown in the cycle after the word is accepted
// throughput: one insert or remove per cycle while the output is not stalled, all cells compare in parallel
// reset: count and output valid cleared; slot contents are left as they are
// depends on spq_pkg and spq_cell
module sorted_priority_queue_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_command,
    input  logic signed [15:0] i_new_priority,
    input  logic signed [15:0] i_new_payload,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_removed_priority,
    output logic signed [15:0] o_removed_payload,
    output logic               o_removed_valid,
    output logic signed [15:0] o_head_priority,
    output logic signed [15:0] o_head_payload,
    output logic               o_head_valid,
    output logic [4:0]         o_entry_count,
    output logic               o_insert_dropped
);
    import spq_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;

    logic             accept;
    logic             full;
    logic             empty;
    logic             do_insert;
    logic             do_remove;
    t_entry           new_entry;

    t_cell_ctl        ctl   [CAPACITY];
    t_entry           cur   [CAPACITY];
    t_entry           nxt   [CAPACITY];
    logic             ge    [CAPACITY];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign empty      = (r_count == '0);
    assign do_insert  = accept && (i_command == CMD_INSERT) && !full;
    assign do_remove  = accept && (i_command == CMD_REMOVE) && !empty;
    assign new_entry  = '{prio: i_new_priority, payload: i_new_payload};

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_entry left_entry;
        t_entry right_entry;
        logic   left_ge;

        assign ctl[i] = '{insert:   do_insert,
                          remove:   do_remove,
                          occupied: (r_count > CNT_W'(i)),
                          at_tail:  (r_count == CNT_W'(i))};

        if (i == 0) begin : g_first
            assign left_entry = new_entry;
            assign left_ge    = 1'b0;
        end else begin : g_mid
            assign left_entry = cur[i-1];
            assign left_ge    = ge[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_entry = cur[i];
        end else begin : g_inner
            assign right_entry = cur[i+1];
        end

        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl[i]),
            .i_new     (new_entry),
            .i_left    (left_entry),
            .i_left_ge (left_ge),
            .i_right   (right_entry),
            .o_entry   (cur[i]),
            .o_next    (nxt[i]),
            .o_ge      (ge[i])
        );
    end

    always_comb begin
        n_count = r_count;
        if (do_insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_remove) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    logic signed [15:0]   r_removed_priority;
    logic signed [15:0]   r_removed_payload;
    logic                 r_removed_valid;
    logic signed [15:0]   r_head_priority;
    logic signed [15:0]   r_head_payload;
    logic                 r_head_valid;
    logic [COUNT_W-1:0]   r_entry_count;
    logic                 r_insert_dropped;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    // count reported modulo 32
    assign count_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (do_remove) begin
                r_removed_priority <= cur[0].prio;
                r_removed_payload  <= cur[0].payload;
            end else begin
                r_removed_priority <= -16'sd1;
                r_removed_payload  <= -16'sd1;
            end
            r_removed_valid <= do_remove;
            if (n_count != '0) begin
                r_head_priority <= nxt[0].prio;
                r_head_payload  <= nxt[0].payload;
                r_head_valid    <= 1'b1;
            end else begin
                r_head_priority <= '0;
                r_head_payload  <= '0;
                r_head_valid    <= 1'b0;
            end
            r_entry_count    <= count_ext[COUNT_W-1:0];
            r_insert_dropped <= (i_command == CMD_INSERT) && full;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_removed_priority = r_removed_priority;
    assign o_removed_payload  = r_removed_payload;
    assign o_removed_valid    = r_removed_valid;
    assign o_head_priority    = r_head_priority;
    assign o_head_payload     = r_head_payload;
    assign o_head_valid       = r_head_valid;
    assign o_entry_count      = r_entry_count;
    assign o_insert_dropped   = r_insert_dropped;

endmodule

// ===== tb/sorted_priority_queue_core_tb.sv =====
// sorted_priority_queue_core_tb: self-checking testbench for the sorted priority queue core
// predicts every result word from its own sorted-slot model and compares field by field
// depends on spq_pkg and sorted_priority_queue_core
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;

    import spq_pkg::*;

    typedef struct {
        logic signed [15:0] rem_prio;
        logic signed [15:0] rem_pay;
        logic               rem_valid;
        logic signed [15:0] head_prio;
        logic signed [15:0] head_pay;
        logic               head_valid;
        logic [4:0]         count;
        logic               dropped;
    } t_queue_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_command;
    logic signed [15:0] i_new_priority;
    logic signed [15:0] i_new_payload;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [15:0] o_removed_priority;
    logic signed [15:0] o_removed_payload;
    logic               o_removed_valid;
    logic signed [15:0] o_head_priority;
    logic signed [15:0] o_head_payload;
    logic               o_head_valid;
    logic [4:0]         o_entry_count;
    logic               o_insert_dropped;

    // queue model: slots kept sorted, slot 0 is the head
    t_entry        model_slots [CAPACITY];
    int            model_count;
    t_queue_result pending_results[$];

    int  error_count;
    int  sink_stall;
    bit  steady_mode;
    int  words_sent;
    int  inserts_sent;
    int  removes_sent;
    int  drops_predicted;
    int  empty_pops;
    int  peak_count;

    sorted_priority_queue_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_new_priority     (i_new_priority),
        .i_new_payload      (i_new_payload),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_removed_priority (o_removed_priority),
        .o_removed_payload  (o_removed_payload),
        .o_removed_valid    (o_removed_valid),
        .o_head_priority    (o_head_priority),
        .o_head_payload     (o_head_payload),
        .o_head_valid       (o_head_valid),
        .o_entry_count      (o_entry_count),
        .o_insert_dropped   (o_insert_dropped)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic t_queue_result predict_queue_step(input logic cmd,
                                                         input logic signed [15:0] prio,
                                                         input logic signed [15:0] pay);
        t_queue_result r;
        int pos;
        r.rem_prio  = -16'sd1;
        r.rem_pay   = -16'sd1;
        r.rem_valid = 1'b0;
        r.dropped   = 1'b0;
        if (cmd == CMD_INSERT) begin
            if (model_count >= CAPACITY) begin
                r.dropped = 1'b1;
            end else begin
                // new word goes ahead of every entry of equal or larger priority
                pos = 0;
                while (pos < model_count && $signed(model_slots[pos].prio) < prio)
                    pos++;
                for (int i = model_count; i > pos; i--)
                    model_slots[i] = model_slots[i-1];
                model_slots[pos].prio    = prio;
                model_slots[pos].payload = pay;
                model_count++;
            end
        end else if (model_count != 0) begin
            r.rem_prio  = model_slots[0].prio;
            r.rem_pay   = model_slots[0].payload;
            r.rem_valid = 1'b1;
            for (int i = 1; i < model_count; i++)
                model_slots[i-1] = model_slots[i];
            model_count--;
        end
        if (model_count != 0) begin
            r.head_prio  = model_slots[0].prio;
            r.head_pay   = model_slots[0].payload;
            r.head_valid = 1'b1;
        end else begin
            r.head_prio  = '0;
            r.head_pay   = '0;
            r.head_valid = 1'b0;
        end
        r.count = model_count[4:0];
        return r;
    endfunction

    // leaves valid high on return so a back-to-back word needs no lowering
    task automatic send_word(input logic cmd, input logic signed [15:0] prio,
                             input logic signed [15:0] pay);
        int gap;
        t_queue_result r;
        gap = steady_mode ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_new_priority <= prio;
        i_new_payload  <= pay;
        do @(posedge i_clk); while (!o_in_ready);
        if (cmd == CMD_REMOVE && model_count == 0)
            empty_pops++;
        r = predict_queue_step(cmd, prio, pay);
        pending_results.push_back(r);
        words_sent++;
        if (cmd == CMD_INSERT)
            inserts_sent++;
        else
            removes_sent++;
        if (r.dropped)
            drops_predicted++;
        if (model_count > peak_count)
            peak_count = model_count;
    endtask

    task automatic insert_word(input logic signed [15:0] prio, input logic signed [15:0] pay);
        send_word(CMD_INSERT, prio, pay);
    endtask

    // priority and payload lines carry noise on a remove, the block must ignore them
    task automatic remove_word();
        send_word(CMD_REMOVE, 16'($urandom), 16'($urandom));
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_priority();
        logic signed [15:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = 16'($signed($urandom_range(0, 8)) - 4);
            5, 6, 7:       v = 16'($urandom);
            default: begin
                case ($urandom_range(0, 5))
                    0:       v = -16'sd32768;
                    1:       v = -16'sd32767;
                    2:       v = -16'sd1;
                    3:       v = 16'sd0;
                    4:       v = 16'sd32766;
                    default: v = 16'sd32767;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic check_result();
        t_queue_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result word with nothing pending", 1, 0);
            return;
        end
        want = pending_results.pop_front();
        if (o_removed_priority !== want.rem_prio)
            report_mismatch("removed_priority", o_removed_priority, want.rem_prio);
        if (o_removed_payload !== want.rem_pay)
            report_mismatch("removed_payload", o_removed_payload, want.rem_pay);
        if (o_removed_valid !== want.rem_valid)
            report_mismatch("removed_valid", o_removed_valid, want.rem_valid);
        if (o_head_priority !== want.head_prio)
            report_mismatch("head_priority", o_head_priority, want.head_prio);
        if (o_head_payload !== want.head_pay)
            report_mismatch("head_payload", o_head_payload, want.head_pay);
        if (o_head_valid !== want.head_valid)
            report_mismatch("head_valid", o_head_valid, want.head_valid);
        if (o_entry_count !== want.count)
            report_mismatch("entry_count", o_entry_count, want.count);
        if (o_insert_dropped !== want.dropped)
            report_mismatch("insert_dropped", o_insert_dropped, want.dropped);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                check_result();
                sink_stall = steady_mode ? 0 : $urandom_range(0, 4);
            end
            if (sink_stall > 0) begin
                i_out_ready <= 1'b0;
                sink_stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic test_remove_on_empty();
        remove_word();
        remove_word();
    endtask

    task automatic test_priority_extremes();
        insert_word(16'sd32767, -16'sd32768);
        insert_word(-16'sd32768, 16'sd32767);
        insert_word(16'sd0, 16'sh5555);
        insert_word(-16'sd1, 16'shAAAA);
        repeat (5) remove_word();
    endtask

    // equal priorities must come out newest first
    task automatic test_equal_priority_order();
        insert_word(16'sd5, 16'sd1);
        insert_word(16'sd5, 16'sd2);
        insert_word(16'sd5, 16'sd3);
        insert_word(16'sd7, 16'sd4);
        insert_word(16'sd3, 16'sd5);
        repeat (5) remove_word();
    endtask

    task automatic test_fill_past_capacity();
        repeat (CAPACITY) insert_word(pick_priority(), 16'($urandom));
        repeat (2) insert_word(pick_priority(), 16'($urandom));
        remove_word();
        insert_word(pick_priority(), 16'($urandom));
        insert_word(pick_priority(), 16'($urandom));
        repeat (CAPACITY + 1) remove_word();
    endtask

    // bursts lean towards filling or draining so the count sweeps its whole range
    task automatic test_random_traffic(input int bursts, input int burst_len);
        int insert_pct;
        for (int b = 0; b < bursts; b++) begin
            case (b % 5)
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                2:       insert_pct = 50;
                3:       insert_pct = 70;
                default: insert_pct = 30;
            endcase
            steady_mode = (b % 4 == 3);
            for (int n = 0; n < burst_len; n++) begin
                if ($urandom_range(1, 100) <= insert_pct)
                    insert_word(pick_priority(), 16'($urandom));
                else
                    remove_word();
            end
        end
        steady_mode = 1'b0;
    endtask

    initial begin
        error_count     = 0;
        model_count     = 0;
        sink_stall      = 0;
        steady_mode     = 1'b0;
        words_sent      = 0;
        inserts_sent    = 0;
        removes_sent    = 0;
        drops_predicted = 0;
        empty_pops      = 0;
        peak_count      = 0;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_command      <= CMD_INSERT;
        i_new_priority <= '0;
        i_new_payload  <= '0;
        i_out_ready    <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_remove_on_empty();
        test_priority_extremes();
        test_equal_priority_order();
        wait_for_drain();
        test_fill_past_capacity();
        wait_for_drain();
        test_random_traffic(15, 100);
        wait_for_drain();

        $display("covered %0d words: %0d inserts, %0d removes", words_sent, inserts_sent,
                 removes_sent);
        $display("full-queue drops %0d, removes on empty %0d, peak occupancy %0d",
                 drops_predicted, empty_pops, peak_count);
        if (error_count == 0) begin
            $display("[sorted_priority_queue_core] OK");
        end else begin
            $display("[sorted_priority_queue_core] ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results still pending", pending_results.size());
        $display("[sorted_priority_queue_core] ERROR");
        $finish;
    end

endmodule
